// ----- design/psd_pkg.sv -----
// Shared constants, types and helper functions for the pairwise squared distance block.
package psd_pkg;

   localparam int MAX_DIM     = 64;
   localparam int MAX_REFS    = 64;
   localparam int STORE_DEPTH = MAX_DIM * MAX_REFS;

   localparam int CFG_W     = 7;
   localparam int CFG_RESET = 64;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_LENGTH   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_COUNT = CSR_IDX_W'(1);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam int VALUE_W    = 16;
   localparam int DIFF_W     = VALUE_W + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int DIST_W     = 40;
   localparam int RIDX_OUT_W = 6;
   localparam int QIDX_W     = 16;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_PAD_W  = RSP_DATA_W - DIST_W - RIDX_OUT_W - QIDX_W;

   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int REF_W   = $clog2(MAX_REFS + 1);
   localparam int TOT_W   = $clog2(STORE_DEPTH + 1);
   localparam int SADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int QADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int MIDX_W  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } mac_ctl_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   function automatic logic [REF_W-1:0] clamp_refs(input logic [CFG_W-1:0] v);
      logic [REF_W-1:0] r;
      if (v == '0) begin
         r = REF_W'(1);
      end else if (int'(v) > MAX_REFS) begin
         r = REF_W'(MAX_REFS);
      end else begin
         r = REF_W'(v);
      end
      return r;
   endfunction

endpackage

// ----- design/pairwise_squared_distance.sv -----
// Pairwise squared distance engine: reference store, query buffer, sequencer, result register.
// Loads and query elements are taken at one transaction per cycle while no query is computing.
// In a completed query each reference takes D store reads through the single MAC, a drain of the
// MAC pipeline and a hand-off of the distance to the output register, which waits while it is full.
// Synchronous reset clears control state and sets both size registers to 64; memories keep data.
module pairwise_squared_distance (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,  // [15:0] value
   input  logic                            req_tuser,  // [0] op
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [63:0]                     rsp_tdata,  // [39:0] distance, [45:40] reference_index,
                                                       // [61:46] query_index, [63:62] zero
   output logic                            rsp_tlast,  // last
   input  logic                            csr_we,
   input  logic [psd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [psd_pkg::CFG_W-1:0]       csr_wdata
);
   import psd_pkg::*;

   state_type           state_ff, state_in;
   logic [CFG_W-1:0]    vlen_ff, vlen_in;
   logic [CFG_W-1:0]    rcnt_ff, rcnt_in;
   logic [SADDR_W-1:0]  lp_ff, lp_in;
   logic [DIM_W-1:0]    qf_ff, qf_in;
   logic [QIDX_W-1:0]   qcnt_ff, qcnt_in;
   logic [QADDR_W-1:0]  d_ff, d_in;
   logic [MIDX_W-1:0]   m_ff, m_in;
   logic [SADDR_W-1:0]  base_ff, base_in;
   mac_ctl_type         ctl_d_ff;
   mac_ctl_type         issue_ctl;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                rsp_last_ff;

   logic [DIM_W-1:0]    d_len;
   logic [REF_W-1:0]    m_cnt;
   logic [TOT_W-1:0]    total;
   logic                req_accept;
   logic                cfg_hit;
   logic                load_wr;
   logic                query_wr;
   logic [SADDR_W-1:0]  ld_addr;
   logic [TOT_W-1:0]    ld_next;
   logic [DIM_W-1:0]    q_wr_idx;
   logic [DIM_W-1:0]    q_next;
   logic                query_done;
   logic                d_last;
   logic                m_last;
   logic                slot_free;
   logic                issue;
   logic                push;
   logic                ready;
   logic [SADDR_W-1:0]  ref_rd_addr;
   logic [VALUE_W-1:0]  ref_rd_data;
   logic [VALUE_W-1:0]  query_rd_data;
   logic [DIST_W-1:0]   mac_acc;
   logic                mac_done;

   assign d_len      = clamp_dim(vlen_ff);
   assign m_cnt      = clamp_refs(rcnt_ff);
   assign total      = TOT_W'(d_len) * TOT_W'(m_cnt);
   assign req_accept = req_tvalid & req_tready;
   assign cfg_hit    = csr_we & ((csr_index == CSR_VECTOR_LENGTH) ||
                                 (csr_index == CSR_REFERENCE_COUNT));
   assign load_wr    = req_accept & (req_tuser == OP_LOAD);
   assign query_wr   = req_accept & (req_tuser == OP_QUERY);

   assign ld_addr    = (TOT_W'(lp_ff) >= total) ? '0 : lp_ff;
   assign ld_next    = TOT_W'(ld_addr) + TOT_W'(1);
   assign q_wr_idx   = (qf_ff >= d_len) ? '0 : qf_ff;
   assign q_next     = q_wr_idx + DIM_W'(1);
   assign query_done = query_wr & (q_next >= d_len);

   assign d_last      = (DIM_W'(d_ff) == d_len - DIM_W'(1));
   assign m_last      = (REF_W'(m_ff) == m_cnt - REF_W'(1));
   assign slot_free   = ~rsp_valid_ff | rsp_tready;
   assign ref_rd_addr = base_ff + SADDR_W'(d_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_done) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (d_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (slot_free) begin
               state_in = m_last ? ST_IDLE : ST_RUN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ready = 1'b0;
      issue = 1'b0;
      push  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  ready = 1'b1;
         ST_RUN:   issue = 1'b1;
         ST_DRAIN: ready = 1'b0;
         ST_PUSH:  push  = slot_free;
         default:  ready = 1'b0;
      endcase
   end

   assign req_tready = ready;

   always_comb begin
      issue_ctl.vld   = issue;
      issue_ctl.first = (d_ff == '0);
      issue_ctl.last  = d_last;
   end

   always_comb begin
      vlen_in = vlen_ff;
      rcnt_in = rcnt_ff;
      if (csr_we && (csr_index == CSR_VECTOR_LENGTH)) begin
         vlen_in = csr_wdata;
      end
      if (csr_we && (csr_index == CSR_REFERENCE_COUNT)) begin
         rcnt_in = csr_wdata;
      end
   end

   always_comb begin
      lp_in = lp_ff;
      qf_in = qf_ff;
      priority if (cfg_hit) begin
         lp_in = '0;
         qf_in = '0;
      end else begin
         if (load_wr) begin
            lp_in = (ld_next >= total) ? '0 : SADDR_W'(ld_next);
         end
         if (query_wr) begin
            qf_in = query_done ? '0 : q_next;
         end
      end
   end

   always_comb begin
      d_in    = d_ff;
      m_in    = m_ff;
      base_in = base_ff;
      qcnt_in = qcnt_ff;
      if (query_done) begin
         d_in    = '0;
         m_in    = '0;
         base_in = '0;
      end
      if (issue) begin
         d_in = d_last ? '0 : d_ff + QADDR_W'(1);
      end
      if (push) begin
         m_in    = m_ff + MIDX_W'(1);
         base_in = base_ff + SADDR_W'(d_len);
         if (m_last) begin
            qcnt_in = qcnt_ff + QIDX_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vlen_ff      <= CFG_W'(CFG_RESET);
         rcnt_ff      <= CFG_W'(CFG_RESET);
         lp_ff        <= '0;
         qf_ff        <= '0;
         qcnt_ff      <= '0;
         d_ff         <= '0;
         m_ff         <= '0;
         base_ff      <= '0;
         ctl_d_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vlen_ff      <= vlen_in;
         rcnt_ff      <= rcnt_in;
         lp_ff        <= lp_in;
         qf_ff        <= qf_in;
         qcnt_ff      <= qcnt_in;
         d_ff         <= d_in;
         m_ff         <= m_in;
         base_ff      <= base_in;
         ctl_d_ff     <= issue_ctl;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, qcnt_ff, RIDX_OUT_W'(m_ff), mac_acc};
         rsp_last_ff <= m_last;
      end
   end

   psd_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_ref_store (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (ld_addr),
      .wr_data (req_tdata),
      .rd_en   (issue),
      .rd_addr (ref_rd_addr),
      .rd_data (ref_rd_data)
   );

   psd_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_DIM)
   ) u_query_buf (
      .clock   (clock),
      .wr_en   (query_wr),
      .wr_addr (q_wr_idx[QADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_en   (issue),
      .rd_addr (d_ff),
      .rd_data (query_rd_data)
   );

   psd_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl_d_ff),
      .ref_value   (ref_rd_data),
      .query_value (query_rd_data),
      .acc         (mac_acc),
      .done        (mac_done)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_load_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      TOT_W'(lp_ff) < total)
      else $error("load pointer outside reference set");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (TOT_W'(ref_rd_addr) < total))
      else $error("reference read outside reference set");

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == ST_DRAIN))
      else $error("accumulator finished outside drain");

endmodule

// ----- design/psd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module psd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/psd_mac.sv -----
// Difference, square and accumulate pipeline for one distance at a time.
module psd_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  psd_pkg::mac_ctl_type                ctl,
   input  logic signed [psd_pkg::VALUE_W-1:0]  ref_value,
   input  logic signed [psd_pkg::VALUE_W-1:0]  query_value,
   output logic [psd_pkg::DIST_W-1:0]          acc,
   output logic                                done
);
   import psd_pkg::*;

   mac_ctl_type              s1_ctl_ff;
   mac_ctl_type              s2_ctl_ff;
   logic signed [DIFF_W-1:0] diff_in;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [SQ_W-1:0]   sq_full;
   logic [SQ_W-1:0]          sq_ff;
   logic [DIST_W-1:0]        acc_in;
   logic [DIST_W-1:0]        acc_ff;
   logic                     done_ff;

   assign diff_in = DIFF_W'(ref_value) - DIFF_W'(query_value);
   assign sq_full = diff_ff * diff_ff;

   always_comb begin
      if (s2_ctl_ff.first) begin
         acc_in = DIST_W'(sq_ff);
      end else begin
         acc_in = acc_ff + DIST_W'(sq_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         s1_ctl_ff <= ctl;
         s2_ctl_ff <= s1_ctl_ff;
         done_ff   <= s2_ctl_ff.vld & s2_ctl_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      sq_ff   <= unsigned'(sq_full);
      if (s2_ctl_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

// ----- test/tb_pairwise_squared_distance.sv -----
// Testbench for pairwise_squared_distance: directed and random loads and queries, scoreboard.
module tb_pairwise_squared_distance;
   timeunit 1ns;
   timeprecision 1ps;

   import psd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = CSR_IDX_W'(3);
   localparam int SETTLE_CYCLES = MAX_DIM + 16;
   localparam int QUIET_LIMIT   = 4000;

   typedef struct packed {
      logic                  last;
      logic [QIDX_W-1:0]     query_index;
      logic [RIDX_OUT_W-1:0] reference_index;
      logic [DIST_W-1:0]     distance;
   } distance_type;

   class distance_scoreboard;
      logic [CFG_W-1:0]          vector_length_reg;
      logic [CFG_W-1:0]          reference_count_reg;
      logic signed [VALUE_W-1:0] reference_store [STORE_DEPTH];
      logic signed [VALUE_W-1:0] query_buffer [MAX_DIM];
      int unsigned               load_pointer;
      int unsigned               query_fill;
      logic [QIDX_W-1:0]         query_counter;
      distance_type              pending_distances[$];
      int                        errors;

      function new();
         vector_length_reg   = CFG_W'(CFG_RESET);
         reference_count_reg = CFG_W'(CFG_RESET);
         load_pointer        = 0;
         query_fill          = 0;
         query_counter       = '0;
         errors              = 0;
      endfunction

      function int unsigned clamped(logic [CFG_W-1:0] v, int unsigned hi);
         if (v == '0) return 1;
         if (int'(v) > hi) return hi;
         return int'(v);
      endfunction

      function int unsigned dim();
         return clamped(vector_length_reg, MAX_DIM);
      endfunction

      function int unsigned refs();
         return clamped(reference_count_reg, MAX_REFS);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] data);
         case (index)
            CSR_VECTOR_LENGTH: vector_length_reg = data;
            CSR_REFERENCE_COUNT: reference_count_reg = data;
            default: return;
         endcase
         load_pointer = 0;
         query_fill   = 0;
      endfunction

      function void accept_element(logic op, logic [VALUE_W-1:0] value);
         int unsigned dl;
         int unsigned mc;
         longint unsigned acc;
         int diff;
         distance_type e;
         dl = dim();
         mc = refs();
         if (op == OP_LOAD) begin
            if (load_pointer >= dl * mc) load_pointer = 0;
            reference_store[load_pointer] = value;
            load_pointer++;
            if (load_pointer >= dl * mc) load_pointer = 0;
            return;
         end
         if (query_fill >= dl) query_fill = 0;
         query_buffer[query_fill] = value;
         query_fill++;
         if (query_fill < dl) return;
         for (int unsigned m = 0; m < mc; m++) begin
            acc = 0;
            for (int unsigned d = 0; d < dl; d++) begin
               diff = int'(reference_store[d + m * dl]) - int'(query_buffer[d]);
               acc += longint'(diff) * longint'(diff);
            end
            e.distance        = acc[DIST_W-1:0];
            e.reference_index = RIDX_OUT_W'(m);
            e.query_index     = query_counter;
            e.last            = (m == mc - 1);
            pending_distances.push_back(e);
         end
         query_fill    = 0;
         query_counter = query_counter + 1'b1;
      endfunction

      function void check_distance(distance_type got);
         distance_type want;
         if (pending_distances.size() == 0) begin
            $error("unexpected distance %0d (reference %0d, query %0d)",
                   got.distance, got.reference_index, got.query_index);
            errors++;
            return;
         end
         want = pending_distances.pop_front();
         if (got.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, got.distance);
            errors++;
         end
         if (got.reference_index !== want.reference_index) begin
            $error("reference_index: expected %0d, got %0d",
                   want.reference_index, got.reference_index);
            errors++;
         end
         if (got.query_index !== want.query_index) begin
            $error("query_index: expected %0d, got %0d", want.query_index, got.query_index);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [15:0]             req_tdata = '0;  // [15:0] value
   logic                    req_tuser = 1'b0;  // [0] op
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [63:0]             rsp_tdata;  // [39:0] distance, [45:40] reference_index,
                                        // [61:46] query_index, [63:62] zero
   logic                    rsp_tlast;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CFG_W-1:0]        csr_wdata = '0;

   distance_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;

   pairwise_squared_distance dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      distance_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.distance        = rsp_tdata[DIST_W-1:0];
         got.reference_index = rsp_tdata[DIST_W +: RIDX_OUT_W];
         got.query_index     = rsp_tdata[DIST_W + RIDX_OUT_W +: QIDX_W];
         got.last            = rsp_tlast;
         sb.check_distance(got);
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [VALUE_W-1:0] rand_element();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return VALUE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_element(logic op, logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      sb.accept_element(op, value);
   endtask

   task automatic drain_distances();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending_distances.size() != 0);
   endtask

   task automatic settle_for_write();
      drain_distances();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size_reg(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(index, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_query_vector();
      int unsigned n;
      n = sb.dim() - sb.query_fill;
      repeat (n) begin
         if ($urandom_range(7) == 0) send_element(OP_LOAD, rand_element());
         send_element(OP_QUERY, rand_element());
      end
   endtask

   task automatic run_phase(logic [CFG_W-1:0] d, logic [CFG_W-1:0] m, int rounds, bit hold_mid);
      int r;
      settle_for_write();
      write_size_reg(CSR_VECTOR_LENGTH, d);
      write_size_reg(CSR_REFERENCE_COUNT, m);
      repeat (sb.dim() * sb.refs()) send_element(OP_LOAD, rand_element());
      for (r = 0; r < rounds; r++) begin
         if (hold_mid && r == rounds / 2) drain_distances();
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) send_element(OP_LOAD, rand_element());
         end else begin
            send_query_vector();
         end
      end
      if (sb.dim() > 1 && $urandom_range(1) == 1) begin
         repeat ($urandom_range(1, sb.dim() - 1)) send_element(OP_QUERY, rand_element());
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct = 18;
      recv_idle_pct = 64;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_size_reg(CSR_VECTOR_LENGTH, 7'd2);
      write_size_reg(CSR_REFERENCE_COUNT, 7'd2);
      send_element(OP_LOAD, 16'h8000);
      send_element(OP_LOAD, 16'h7fff);
      send_element(OP_LOAD, 16'h7fff);
      send_element(OP_LOAD, 16'h8000);
      send_element(OP_QUERY, 16'h7fff);
      send_element(OP_QUERY, 16'h8000);
      send_element(OP_QUERY, 16'h8000);
      send_element(OP_QUERY, 16'h0000);
      // overfill the store so the load pointer wraps
      send_element(OP_LOAD, 16'h0000);
      send_element(OP_LOAD, 16'h0001);
      send_element(OP_LOAD, 16'h8000);
      send_element(OP_LOAD, 16'h7fff);
      send_element(OP_LOAD, 16'h00ff);
      send_element(OP_QUERY, 16'h0100);
      settle_for_write();
      write_size_reg(CSR_UNMAPPED, 7'h55);
      send_element(OP_QUERY, 16'hffff);
      send_element(OP_QUERY, 16'h0007);
      settle_for_write();
      write_size_reg(CSR_VECTOR_LENGTH, 7'd2);
      send_element(OP_QUERY, 16'h0001);
      send_element(OP_QUERY, 16'h0002);
      send_element(OP_QUERY, 16'h0003);
      send_element(OP_LOAD, 16'h0009);
      send_element(OP_QUERY, 16'hfffb);

      run_phase(7'd3, 7'd4, 4, 1'b1);

      send_idle_pct = 64;
      recv_idle_pct = 18;
      run_phase(7'd0, 7'd0, 6, 1'b0);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(7'd1, 7'd127, 2, 1'b0);

      drain_distances();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_distances.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/psd_pkg.sv
design/psd_ram.sv
design/psd_mac.sv
design/pairwise_squared_distance.sv
test/tb_pairwise_squared_distance.sv
